// ===== rtl/core/sha2_pkg.sv =====
// Shared constants and types for the SHA-256 / SHA-224 hash unit.
// Holds round constants, initial hash values and the sequencer-to-core command struct.
// No dependencies; compile first.
`default_nettype none

package sha2_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned HASH_WORDS  = 8;
  localparam int unsigned SCHED_DEPTH = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned ROUND_W     = 6;
  localparam int unsigned BYTE_CNT_W  = 61;
  localparam int unsigned BLK_CNT_W   = 4;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef logic [WORD_W-1:0]                  sha2_word_t;
  typedef logic [HASH_WORDS-1:0][WORD_W-1:0]  sha2_hash_t;

  // Register indexes of the configuration port
  localparam logic [0:0] REG_DIGEST_MODE = 1'b0;

  // Digest modes
  localparam logic MODE_SHA256 = 1'b0;
  localparam logic MODE_SHA224 = 1'b1;

  // Index of the final digest word per mode
  localparam logic [2:0] LAST_IDX_256 = 3'd7;
  localparam logic [2:0] LAST_IDX_224 = 3'd6;

  // Padding
  localparam logic [2:0]  FULL_BYTES = 3'd4;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam sha2_word_t  PAD_WORD   = 32'h8000_0000;
  localparam logic [BLK_CNT_W-1:0] LEN_HI_SLOT = 4'd14;
  localparam logic [BLK_CNT_W-1:0] BLOCK_END   = 4'd15;

  // Initial hash values, element 0 is H0
  localparam sha2_hash_t IV256 = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };
  localparam sha2_hash_t IV224 = {
    32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
    32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
  };

  // Round constants
  localparam sha2_word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Command from the padding sequencer to the compression core
  typedef struct packed {
    logic       push;   // shift one word into the schedule
    sha2_word_t word;   // word to shift in
    logic       start;  // begin 64 rounds on the current schedule
    logic       init;   // reload the chained hash with initial values
    logic       mode;   // mode that selects the initial values
  } sha2_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sha2_ifs.sv =====
// Valid/ready channel interfaces for the hash unit: message words in, digest words out.
// Depends on sha2_pkg for the word type.
`default_nettype none

interface sha2_in_if;
  logic                valid;
  logic                ready;
  sha2_pkg::sha2_word_t msg_word;
  logic [2:0]          valid_bytes;
  logic                last_word;

  modport source (output valid, output msg_word, output valid_bytes, output last_word,
                  input ready);
  modport sink   (input valid, input msg_word, input valid_bytes, input last_word,
                  output ready);
endinterface

interface sha2_out_if;
  logic                valid;
  logic                ready;
  sha2_pkg::sha2_word_t digest_word;
  logic [2:0]          word_index;
  logic                last_digest;

  modport source (output valid, output digest_word, output word_index, output last_digest,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_digest,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha2_compress.sv =====
// SHA-256 compression core: 16-word schedule shift line, working variables and
// chained hash, one round per cycle on a single shared round datapath. Uses sha2_pkg.
`default_nettype none

module sha2_compress (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire sha2_pkg::sha2_cmd_t cmd,
  output logic                   done,
  output sha2_pkg::sha2_hash_t   chain
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FOLD  = 3'b100
  } core_state_t;

  core_state_t                        state_r, state_nxt;
  logic [sha2_pkg::ROUND_W-1:0]       round_r, round_nxt;
  sha2_pkg::sha2_hash_t               work_r, work_nxt;
  sha2_pkg::sha2_hash_t               chain_r;
  sha2_pkg::sha2_word_t               sched_r [sha2_pkg::SCHED_DEPTH];
  sha2_pkg::sha2_word_t               sched_new;
  sha2_pkg::sha2_word_t               t1, t2;

  function automatic sha2_pkg::sha2_word_t bsig0(sha2_pkg::sha2_word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic sha2_pkg::sha2_word_t bsig1(sha2_pkg::sha2_word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic sha2_pkg::sha2_word_t ssig0(sha2_pkg::sha2_word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic sha2_pkg::sha2_word_t ssig1(sha2_pkg::sha2_word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  // One round: t1/t2 and the next schedule word
  always_comb begin
    t1 = work_r[7] + bsig1(work_r[4])
       + (work_r[6] ^ (work_r[4] & (work_r[5] ^ work_r[6])))
       + sha2_pkg::ROUND_K[round_r] + sched_r[0];
    t2 = bsig0(work_r[0])
       + ((work_r[0] & work_r[1]) | (work_r[2] & (work_r[0] | work_r[1])));
    sched_new = ssig1(sched_r[14]) + sched_r[9] + ssig0(sched_r[1]) + sched_r[0];
  end

  // Sequence: idle, 64 rounds, fold into the chained hash
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    work_nxt  = work_r;
    case (state_r)
      C_IDLE: begin
        if (cmd.start) begin
          state_nxt = C_ROUND;
          round_nxt = '0;
          work_nxt  = chain_r;
        end
      end
      C_ROUND: begin
        work_nxt[0] = t1 + t2;
        work_nxt[1] = work_r[0];
        work_nxt[2] = work_r[1];
        work_nxt[3] = work_r[2];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[5] = work_r[4];
        work_nxt[6] = work_r[5];
        work_nxt[7] = work_r[6];
        round_nxt   = round_r + 1'b1;
        if (round_r == sha2_pkg::ROUND_W'(sha2_pkg::ROUNDS - 1)) begin
          state_nxt = C_FOLD;
        end
      end
      C_FOLD: begin
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
        round_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  // Advance the schedule line on every pushed word and every round
  always_ff @(posedge clk) begin
    if (cmd.push || (state_r == C_ROUND)) begin
      for (int i = 0; i < sha2_pkg::SCHED_DEPTH - 1; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[sha2_pkg::SCHED_DEPTH-1] <= cmd.push ? cmd.word : sched_new;
    end
  end

  // Chained hash: reload on init, add working variables after the last round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sha2_pkg::IV256;
    end else if (cmd.init) begin
      chain_r <= (cmd.mode == sha2_pkg::MODE_SHA224) ? sha2_pkg::IV224 : sha2_pkg::IV256;
    end else if (state_r == C_FOLD) begin
      for (int i = 0; i < sha2_pkg::HASH_WORDS; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  assign done  = (state_r == C_FOLD);
  assign chain = chain_r;

  a_fold_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_FOLD) |=> (state_r == C_IDLE))
    else $error("fold lasted more than one cycle");

  a_round_64: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_ROUND && round_r == sha2_pkg::ROUND_W'(sha2_pkg::ROUNDS - 1))
      |=> (state_r == C_FOLD))
    else $error("round 63 not followed by fold");

  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != C_ROUND) |-> (round_r == '0) || (state_r == C_FOLD))
    else $error("round counter moved outside the round phase");

endmodule

`default_nettype wire

// ===== rtl/core/sha256_sha224_hash_unit.sv =====
// Top level of the SHA-256 / SHA-224 hash unit: input handshake, padding sequencer,
// digest output register and configuration port. Uses sha2_pkg, sha2_ifs, sha2_compress.
//
//   port     | dir | what moves
//   ---------+-----+-----------------------------------------------------------
//   in_ch    | in  | message word, valid byte count, last-word flag
//   out_ch   | out | digest word, word position, final-word flag
//   cfg_*    | in  | APB write/read of digest_mode at byte address 0
//
// A word that does not complete a block only shifts into the schedule. A word that
// completes a block also starts the shared round datapath (64 rounds plus a fold).
// The last word adds the padding words and one or two blocks, then loads 8 (SHA-256)
// or 7 (SHA-224) digest words, one per output transfer.
// Reset is synchronous, active low; no clearing pass is needed after it.
// in_ch is ready only while the sequencer is idle; the output register lets the next
// message start while the final digest word still waits for its transfer.
`default_nettype none

module sha256_sha224_hash_unit (
  input  wire                                   clk,
  input  wire                                   rst_n,
  sha2_in_if.sink                               in_ch,
  sha2_out_if.source                            out_ch,
  input  wire                                   cfg_psel,
  input  wire                                   cfg_penable,
  input  wire                                   cfg_pwrite,
  input  wire  [sha2_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire  [sha2_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [sha2_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } seq_state_t;

  seq_state_t                            state_r, state_nxt;
  logic                                  mode_r;
  logic [sha2_pkg::BYTE_CNT_W-1:0]       bytes_r, bytes_nxt;
  logic [sha2_pkg::BLK_CNT_W-1:0]        wib_r, wib_nxt;
  logic                                  pad_r, pad_nxt;
  logic                                  extra_r, extra_nxt;
  logic                                  len_hi_r, len_hi_nxt;
  logic                                  len_lo_r, len_lo_nxt;
  logic [2:0]                            idx_r, idx_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  sha2_pkg::sha2_word_t                  out_word_r;
  logic [2:0]                            out_idx_r;
  logic                                  out_last_r;

  sha2_pkg::sha2_cmd_t                   cmd;
  sha2_pkg::sha2_hash_t                  chain;
  logic                                  core_done;

  logic                                  in_fire;
  logic                                  cfg_wr;
  logic                                  cfg_sel_mode;
  logic [2:0]                            nv_clamp;
  logic [2:0]                            last_idx;
  logic                                  out_load;
  logic                                  out_final;
  sha2_pkg::sha2_word_t                  in_word;
  sha2_pkg::sha2_word_t                  pad_word;

  // Keep the valid high-order bytes and place the pad byte right after them
  function automatic sha2_pkg::sha2_word_t pad_tail(sha2_pkg::sha2_word_t w,
                                                    logic [2:0] nv);
    sha2_pkg::sha2_word_t r;
    case (nv)
      3'd0:    r = sha2_pkg::PAD_WORD;
      3'd1:    r = {w[31:24], sha2_pkg::PAD_BYTE, 16'h0000};
      3'd2:    r = {w[31:16], sha2_pkg::PAD_BYTE, 8'h00};
      3'd3:    r = {w[31:8],  sha2_pkg::PAD_BYTE};
      default: r = w;
    endcase
    return r;
  endfunction

  sha2_compress u_compress (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .done  (core_done),
    .chain (chain)
  );

  // Configuration port
  assign cfg_pready   = 1'b1;
  assign cfg_sel_mode = (cfg_paddr[sha2_pkg::CFG_ADDR_W-1:2] == sha2_pkg::REG_DIGEST_MODE);
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_mode;
  assign cfg_prdata   = cfg_sel_mode ? {{(sha2_pkg::CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sha2_pkg::MODE_SHA256;
    end else if (cfg_wr) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // Input side
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign nv_clamp    = (in_ch.valid_bytes > sha2_pkg::FULL_BYTES) ? sha2_pkg::FULL_BYTES
                                                                   : in_ch.valid_bytes;
  assign in_word     = (in_ch.last_word && nv_clamp != sha2_pkg::FULL_BYTES)
                       ? pad_tail(in_ch.msg_word, nv_clamp) : in_ch.msg_word;

  // Padding word: pad word, zero fill, then the 64-bit bit length
  always_comb begin
    if (extra_r) begin
      pad_word = sha2_pkg::PAD_WORD;
    end else if (len_hi_r) begin
      pad_word = {bytes_r[28:0], 3'b000};
    end else if (wib_r == sha2_pkg::LEN_HI_SLOT) begin
      pad_word = bytes_r[60:29];
    end else begin
      pad_word = '0;
    end
  end

  // Output side
  assign last_idx  = (mode_r == sha2_pkg::MODE_SHA224) ? sha2_pkg::LAST_IDX_224
                                                       : sha2_pkg::LAST_IDX_256;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign out_final = out_load && (idx_r == last_idx);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    bytes_nxt     = bytes_r;
    wib_nxt       = wib_r;
    pad_nxt       = pad_r;
    extra_nxt     = extra_r;
    len_hi_nxt    = len_hi_r;
    len_lo_nxt    = len_lo_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.mode      = cfg_wr ? cfg_pwdata[0] : mode_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.push = 1'b1;
          cmd.word = in_word;
          wib_nxt  = wib_r + 1'b1;
          if (in_ch.last_word) begin
            bytes_nxt = bytes_r + sha2_pkg::BYTE_CNT_W'(nv_clamp);
            pad_nxt   = 1'b1;
            extra_nxt = (nv_clamp == sha2_pkg::FULL_BYTES);
          end else begin
            bytes_nxt = bytes_r + sha2_pkg::BYTE_CNT_W'(sha2_pkg::FULL_BYTES);
          end
          if (wib_r == sha2_pkg::BLOCK_END) begin
            cmd.start = 1'b1;
            state_nxt = S_COMP;
          end else if (in_ch.last_word) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        cmd.word = pad_word;
        wib_nxt  = wib_r + 1'b1;
        if (extra_r) begin
          extra_nxt = 1'b0;
        end else if (len_hi_r) begin
          len_lo_nxt = 1'b1;
        end else if (wib_r == sha2_pkg::LEN_HI_SLOT) begin
          len_hi_nxt = 1'b1;
        end
        if (wib_r == sha2_pkg::BLOCK_END) begin
          cmd.start = 1'b1;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (core_done) begin
          if (len_lo_r) begin
            state_nxt = S_OUT;
          end else if (pad_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          idx_nxt       = idx_r + 1'b1;
        end
        if (out_final) begin
          cmd.init   = 1'b1;
          state_nxt  = S_IDLE;
          idx_nxt    = '0;
          bytes_nxt  = '0;
          wib_nxt    = '0;
          pad_nxt    = 1'b0;
          extra_nxt  = 1'b0;
          len_hi_nxt = 1'b0;
          len_lo_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Mode write reloads the initial hash and clears the byte count and block position
    if (cfg_wr) begin
      cmd.init  = 1'b1;
      bytes_nxt = '0;
      wib_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bytes_r     <= '0;
      wib_r       <= '0;
      pad_r       <= 1'b0;
      extra_r     <= 1'b0;
      len_hi_r    <= 1'b0;
      len_lo_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bytes_r     <= bytes_nxt;
      wib_r       <= wib_nxt;
      pad_r       <= pad_nxt;
      extra_r     <= extra_nxt;
      len_hi_r    <= len_hi_nxt;
      len_lo_r    <= len_lo_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the digest word until its transfer
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= chain[idx_r];
      out_idx_r  <= idx_r;
      out_last_r <= (idx_r == last_idx);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_digest = out_last_r;

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> (state_r == S_COMP))
    else $error("compression finished outside the wait state");

  a_last_pads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_word && !cfg_wr) |=> pad_r)
    else $error("last word did not start padding");

  a_len_lo_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAD && len_hi_r && !extra_r) |-> (wib_r == sha2_pkg::BLOCK_END))
    else $error("low length word not in the final schedule slot");

endmodule

`default_nettype wire
